>>> sv/mpe_pkg.sv
package mpe_pkg;

  localparam int unsigned EncBytes = 9;
  localparam int unsigned LenWidth = $clog2(EncBytes + 1);

  typedef enum logic [2:0] {
    FUNC_NIL   = 3'd0,
    FUNC_BOOL  = 3'd1,
    FUNC_INT   = 3'd2,
    FUNC_FLOAT = 3'd3,
    FUNC_STR   = 3'd4,
    FUNC_ARRAY = 3'd5,
    FUNC_MAP   = 3'd6,
    FUNC_BYTE  = 3'd7
  } func_t;

  localparam logic [7:0] TagNil      = 8'hc0;
  localparam logic [7:0] TagFalse    = 8'hc2;
  localparam logic [7:0] TagTrue     = 8'hc3;
  localparam logic [7:0] TagFloat64  = 8'hcb;
  localparam logic [7:0] TagUint8    = 8'hcc;
  localparam logic [7:0] TagUint16   = 8'hcd;
  localparam logic [7:0] TagUint32   = 8'hce;
  localparam logic [7:0] TagUint64   = 8'hcf;
  localparam logic [7:0] TagInt8     = 8'hd0;
  localparam logic [7:0] TagInt16    = 8'hd1;
  localparam logic [7:0] TagInt32    = 8'hd2;
  localparam logic [7:0] TagInt64    = 8'hd3;
  localparam logic [7:0] TagNegFix   = 8'he0;
  localparam logic [7:0] TagFixStr   = 8'ha0;
  localparam logic [7:0] TagStr8     = 8'hd9;
  localparam logic [7:0] TagStr16    = 8'hda;
  localparam logic [7:0] TagStr32    = 8'hdb;
  localparam logic [7:0] TagFixArray = 8'h90;
  localparam logic [7:0] TagArray16  = 8'hdc;
  localparam logic [7:0] TagArray32  = 8'hdd;
  localparam logic [7:0] TagFixMap   = 8'h80;
  localparam logic [7:0] TagMap16    = 8'hde;
  localparam logic [7:0] TagMap32    = 8'hdf;

  typedef struct packed {
    logic [EncBytes-1:0][7:0] bytes;
    logic [LenWidth-1:0]      len;
  } enc_item_t;

endpackage

>>> sv/mpe_if.sv
interface mpe_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic signed [63:0] value;
  logic [7:0]         payload_byte;

  modport source (output valid, func, value, payload_byte, input ready);
  modport sink (input valid, func, value, payload_byte, output ready);
endinterface

interface mpe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink (input valid, out_byte, last_byte, output ready);
endinterface

>>> sv/mpe_front.sv
module mpe_front
  import mpe_pkg::*;
(
  mpe_in_if.sink    in_chan,
  output logic      push_valid,
  output enc_item_t push_item,
  input  logic      push_ready
);

  function automatic logic [7:0][7:0] put_be(input logic [63:0] v, input int k);
    logic [7:0][7:0] t;
    t = '0;
    for (int j = 0; j < 8; j++) begin
      if (j < k) begin
        t[j] = v[8*(k-1-j) +: 8];
      end
    end
    return t;
  endfunction

  logic [63:0] u;
  logic [31:0] low;
  logic [7:0]  hdr;
  logic [7:0][7:0] tail;
  logic [LenWidth-1:0] len;

  assign u   = in_chan.value;
  assign low = u[31:0];

  always_comb begin
    hdr  = TagNil;
    tail = '0;
    len  = LenWidth'(1);
    case (func_t'(in_chan.func))
      FUNC_NIL: begin
        hdr = TagNil;
      end
      FUNC_BOOL: begin
        hdr = (u != '0) ? TagTrue : TagFalse;
      end
      FUNC_INT: begin
        if (!u[63]) begin
          if (u[63:7] == '0) begin
            hdr = u[7:0];
          end else if (u[63:8] == '0) begin
            hdr = TagUint8; tail = put_be(u, 1); len = LenWidth'(2);
          end else if (u[63:16] == '0) begin
            hdr = TagUint16; tail = put_be(u, 2); len = LenWidth'(3);
          end else if (u[63:32] == '0) begin
            hdr = TagUint32; tail = put_be(u, 4); len = LenWidth'(5);
          end else begin
            hdr = TagUint64; tail = put_be(u, 8); len = LenWidth'(9);
          end
        end else begin
          if (&u[63:5]) begin
            hdr = TagNegFix | {3'b000, u[4:0]};
          end else if (&u[63:7]) begin
            hdr = TagInt8; tail = put_be(u, 1); len = LenWidth'(2);
          end else if (&u[63:15]) begin
            hdr = TagInt16; tail = put_be(u, 2); len = LenWidth'(3);
          end else if (&u[63:31]) begin
            hdr = TagInt32; tail = put_be(u, 4); len = LenWidth'(5);
          end else begin
            hdr = TagInt64; tail = put_be(u, 8); len = LenWidth'(9);
          end
        end
      end
      FUNC_FLOAT: begin
        hdr = TagFloat64; tail = put_be(u, 8); len = LenWidth'(9);
      end
      FUNC_STR: begin
        if (low[31:5] == '0) begin
          hdr = TagFixStr | {3'b000, low[4:0]};
        end else if (low[31:8] == '0) begin
          hdr = TagStr8; tail = put_be({32'd0, low}, 1); len = LenWidth'(2);
        end else if (low[31:16] == '0) begin
          hdr = TagStr16; tail = put_be({32'd0, low}, 2); len = LenWidth'(3);
        end else begin
          hdr = TagStr32; tail = put_be({32'd0, low}, 4); len = LenWidth'(5);
        end
      end
      FUNC_ARRAY, FUNC_MAP: begin
        if (low[31:4] == '0) begin
          hdr = ((func_t'(in_chan.func) == FUNC_ARRAY) ? TagFixArray : TagFixMap)
                | {4'b0000, low[3:0]};
        end else if (low[31:16] == '0) begin
          hdr  = (func_t'(in_chan.func) == FUNC_ARRAY) ? TagArray16 : TagMap16;
          tail = put_be({32'd0, low}, 2);
          len  = LenWidth'(3);
        end else begin
          hdr  = (func_t'(in_chan.func) == FUNC_ARRAY) ? TagArray32 : TagMap32;
          tail = put_be({32'd0, low}, 4);
          len  = LenWidth'(5);
        end
      end
      FUNC_BYTE: begin
        hdr = in_chan.payload_byte;
      end
      default: begin
        hdr = in_chan.payload_byte;
      end
    endcase
  end

  assign push_valid           = in_chan.valid;
  assign push_item.bytes[0]   = hdr;
  assign push_item.bytes[8:1] = tail;
  assign push_item.len        = len;
  assign in_chan.ready        = push_ready;

endmodule

>>> sv/mpe_queue.sv
module mpe_queue
  import mpe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  input  enc_item_t push_item,
  output logic      push_ready,
  output logic      pop_valid,
  output enc_item_t pop_item,
  input  logic      pop_ready
);

  enc_item_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

>>> sv/mpe_back.sv
module mpe_back
  import mpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  enc_item_t   q_item,
  output logic        q_pop,
  input  logic        capacity_we,
  input  logic [31:0] capacity_data,
  mpe_out_if.source   out_chan
);

  logic [31:0]         capacity;
  logic [31:0]         write_position;
  logic [LenWidth-1:0] idx;
  logic                out_valid;
  logic [7:0]          out_byte;
  logic                last_byte;

  logic load_ok;
  logic full;
  logic last;
  logic emit;

  assign load_ok = !out_valid || out_chan.ready;
  assign full    = (write_position >= capacity);
  // last byte of the item, or the buffer fills on this byte
  assign last    = (idx == q_item.len - LenWidth'(1))
                   || (({1'b0, write_position} + 33'd1) == {1'b0, capacity});
  assign emit    = q_valid && load_ok && !full;
  assign q_pop   = q_valid && load_ok && (full || last);

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte  <= q_item.bytes[idx[LenWidth-1:0]];
      last_byte <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity       <= '1;
      write_position <= '0;
      idx            <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (capacity_we) begin
        capacity <= capacity_data;
      end
      if (emit) begin
        write_position <= write_position + 32'd1;
      end
      if (q_pop) begin
        idx <= '0;
      end else if (emit) begin
        idx <= idx + LenWidth'(1);
      end
      if (load_ok) begin
        out_valid <= emit;
      end
    end
  end

  assign out_chan.valid     = out_valid;
  assign out_chan.out_byte  = out_byte;
  assign out_chan.last_byte = last_byte;

endmodule

>>> sv/messagepack_value_encoder_unit.sv
// messagepack value encoder
// in_chan takes one request per value: a kind code, a 64-bit value and a
// payload byte. out_chan delivers the encoded stream one byte per transfer,
// with last_byte set on the final byte sent for that request.
// capacity_we/capacity_data write the byte capacity; bytes at or past it are
// dropped, and a request whose bytes are all dropped produces nothing.
// the front end encodes a request in the cycle it is taken and writes it into
// a two-entry queue; the back end sends one byte per cycle from the queue head
// into an output register, while out_chan does not stall.
// a request's bytes pass through a queue entry and then the output register.
// one byte per cycle without stalls; a request of 1 to 9 bytes holds the back
// end until its last byte is sent, so payload bytes stream at one request per
// cycle. when out_chan stalls, the output register holds its byte, the back
// end waits, and in_chan keeps taking requests until the queue is full.
// reset (rst, synchronous) empties the queue and output register, clears the
// write position and sets capacity to all ones.
module messagepack_value_encoder_unit
  import mpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  mpe_in_if.sink      in_chan,
  mpe_out_if.source   out_chan,
  input  logic        capacity_we,
  input  logic [31:0] capacity_data
);

  logic      push_valid;
  enc_item_t push_item;
  logic      push_ready;
  logic      q_valid;
  enc_item_t q_item;
  logic      q_pop;

  mpe_front u_front (
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  mpe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop_ready  (q_pop)
  );

  mpe_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .capacity_we   (capacity_we),
    .capacity_data (capacity_data),
    .out_chan      (out_chan)
  );

endmodule

>>> bench/tb.sv
module tb;
  import mpe_pkg::*;

  localparam int QuietLimit = 2000;

  typedef struct packed {
    func_t       func;
    logic [63:0] value;
    logic [7:0]  pb;
  } enc_request_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        capacity_we;
  logic [31:0] capacity_data;

  mpe_in_if  in_if ();
  mpe_out_if out_if ();

  messagepack_value_encoder_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_chan      (in_if),
    .out_chan     (out_if),
    .capacity_we  (capacity_we),
    .capacity_data(capacity_data)
  );

  always #1 clk = ~clk;

  enc_request_t request_queue[$];
  stream_byte_t expected_stream[$];
  enc_request_t cur_req;
  stream_byte_t exp_byte;

  logic [31:0] model_capacity = 32'hffff_ffff;
  logic [31:0] model_pos = 32'h0;
  bit          in_took;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          rx_hold_left;
  int          quiet_cycles;
  int          requests_taken;
  int          bytes_seen;
  int          errors;

  function automatic void encode_value(input func_t f, input logic [63:0] v,
                                       input logic [7:0] pb);
    logic [7:0]      tag;
    logic [63:0]     body;
    logic [31:0]     low;
    logic [7:0]      b;
    int              k;
    int              cnt;
    int              i;
    longint unsigned avail;
    low  = v[31:0];
    body = v;
    k    = 0;
    case (f)
      FUNC_NIL:   tag = TagNil;
      FUNC_BOOL:  tag = (v != 64'h0) ? TagTrue : TagFalse;
      FUNC_INT: begin
        if (!v[63]) begin
          if (v <= 64'd127) tag = v[7:0];
          else if (v <= 64'hff) begin tag = TagUint8; k = 1; end
          else if (v <= 64'hffff) begin tag = TagUint16; k = 2; end
          else if (v <= 64'hffff_ffff) begin tag = TagUint32; k = 4; end
          else begin tag = TagUint64; k = 8; end
        end else if (v >= 64'hffff_ffff_ffff_ffe0) tag = TagNegFix | {3'b000, v[4:0]};
        else if (v >= 64'hffff_ffff_ffff_ff80) begin tag = TagInt8; k = 1; end
        else if (v >= 64'hffff_ffff_ffff_8000) begin tag = TagInt16; k = 2; end
        else if (v >= 64'hffff_ffff_8000_0000) begin tag = TagInt32; k = 4; end
        else begin tag = TagInt64; k = 8; end
      end
      FUNC_FLOAT: begin
        tag = TagFloat64;
        k = 8;
      end
      FUNC_STR: begin
        body = {32'h0, low};
        if (low <= 32'd31) tag = TagFixStr | low[7:0];
        else if (low <= 32'hff) begin tag = TagStr8; k = 1; end
        else if (low <= 32'hffff) begin tag = TagStr16; k = 2; end
        else begin tag = TagStr32; k = 4; end
      end
      FUNC_ARRAY: begin
        body = {32'h0, low};
        if (low <= 32'd15) tag = TagFixArray | low[7:0];
        else if (low <= 32'hffff) begin tag = TagArray16; k = 2; end
        else begin tag = TagArray32; k = 4; end
      end
      FUNC_MAP: begin
        body = {32'h0, low};
        if (low <= 32'd15) tag = TagFixMap | low[7:0];
        else if (low <= 32'hffff) begin tag = TagMap16; k = 2; end
        else begin tag = TagMap32; k = 4; end
      end
      default:    tag = pb;
    endcase
    // bytes past capacity are dropped
    avail = (model_pos >= model_capacity) ? 0 : model_capacity - model_pos;
    cnt = (avail < k + 1) ? int'(avail) : k + 1;
    for (i = 0; i < cnt; i++) begin
      b = (i == 0) ? tag : 8'(body >> (8 * (k - i)));
      expected_stream.push_back('{b, i == cnt - 1});
    end
    model_pos = model_pos + cnt;
  endfunction

  function automatic logic [63:0] random_value();
    logic [63:0] r;
    r = {$urandom, $urandom} >> $urandom_range(63);
    if ($urandom_range(1)) r = ~r;
    return r;
  endfunction

  task automatic queue_random(input int count);
    int len;
    repeat (count) begin
      if ($urandom_range(3) == 0) begin
        // string header followed by its payload
        len = $urandom_range(6);
        request_queue.push_back('{FUNC_STR, {$urandom, 32'(len)}, 8'($urandom)});
        repeat (len) request_queue.push_back('{FUNC_BYTE, random_value(), 8'($urandom)});
      end else begin
        request_queue.push_back('{func_t'($urandom_range(7)), random_value(), 8'($urandom)});
      end
    end
  endtask

  task automatic drain();
    while (request_queue.size() != 0 || in_if.valid || expected_stream.size() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [31:0] c);
    @(negedge clk);
    capacity_we   <= 1'b1;
    capacity_data <= c;
    @(negedge clk);
    capacity_we   <= 1'b0;
    model_capacity = c;
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_took) begin
      if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_req = request_queue.pop_front();
        in_if.valid        <= 1'b1;
        in_if.func         <= cur_req.func;
        in_if.value        <= cur_req.value;
        in_if.payload_byte <= cur_req.pb;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // output acceptance, with long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_if.ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      out_if.ready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    in_took = !rst && in_if.valid && in_if.ready;
    if (in_took) begin
      encode_value(func_t'(in_if.func), in_if.value, in_if.payload_byte);
      requests_taken++;
    end
    if (!rst && out_if.valid && out_if.ready) begin
      bytes_seen++;
      if (expected_stream.size() == 0) begin
        $display("%0t unexpected byte: got %h last %b", $time, out_if.out_byte,
                 out_if.last_byte);
        errors++;
      end else begin
        exp_byte = expected_stream.pop_front();
        if (exp_byte.data !== out_if.out_byte || exp_byte.last !== out_if.last_byte) begin
          $display("%0t mismatch: expected %h last %b, got %h last %b", $time,
                   exp_byte.data, exp_byte.last, out_if.out_byte, out_if.last_byte);
          errors++;
        end
      end
    end
    if (rst || in_took || (out_if.valid && out_if.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == QuietLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    rst                = 1'b1;
    capacity_we        = 1'b0;
    capacity_data      = 32'h0;
    in_if.valid        = 1'b0;
    in_if.func         = FUNC_NIL;
    in_if.value        = 64'h0;
    in_if.payload_byte = 8'h0;
    out_if.ready       = 1'b0;
    send_idle_pct      = 11;
    recv_idle_pct      = 70;
    rx_hold_left       = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: tags, int and length boundaries, ignored fields
    request_queue.push_back('{FUNC_NIL, 64'hdead_beef_0123_4567, 8'h5a});
    request_queue.push_back('{FUNC_BOOL, 64'h0, 8'hff});
    request_queue.push_back('{FUNC_BOOL, 64'h8000_0000_0000_0000, 8'h00});
    request_queue.push_back('{FUNC_INT, 64'd0, 8'h00});
    request_queue.push_back('{FUNC_INT, 64'd127, 8'h00});
    request_queue.push_back('{FUNC_INT, 64'd128, 8'h00});
    request_queue.push_back('{FUNC_INT, 64'd256, 8'h00});
    request_queue.push_back('{FUNC_INT, 64'd65536, 8'h00});
    request_queue.push_back('{FUNC_INT, 64'h1_0000_0000, 8'h00});
    request_queue.push_back('{FUNC_INT, 64'h7fff_ffff_ffff_ffff, 8'h00});
    request_queue.push_back('{FUNC_INT, -64'sd1, 8'h00});
    request_queue.push_back('{FUNC_INT, -64'sd32, 8'h00});
    request_queue.push_back('{FUNC_INT, -64'sd33, 8'h00});
    request_queue.push_back('{FUNC_INT, -64'sd129, 8'h00});
    request_queue.push_back('{FUNC_INT, -64'sd32769, 8'h00});
    request_queue.push_back('{FUNC_INT, 64'hffff_ffff_7fff_ffff, 8'h00});
    request_queue.push_back('{FUNC_INT, 64'h8000_0000_0000_0000, 8'h00});
    request_queue.push_back('{FUNC_FLOAT, 64'h4009_21fb_5444_2d18, 8'h00});
    request_queue.push_back('{FUNC_STR, 64'd31, 8'h00});
    request_queue.push_back('{FUNC_STR, 64'd32, 8'h00});
    request_queue.push_back('{FUNC_STR, 64'hffff_ffff_0000_0100, 8'h00});
    request_queue.push_back('{FUNC_STR, 64'h1_0001_0000, 8'h00});
    request_queue.push_back('{FUNC_ARRAY, 64'd15, 8'h00});
    request_queue.push_back('{FUNC_ARRAY, 64'd16, 8'h00});
    request_queue.push_back('{FUNC_ARRAY, 64'h0000_0000_ffff_ffff, 8'h00});
    request_queue.push_back('{FUNC_MAP, 64'hffff_ffff_0000_000f, 8'h00});
    request_queue.push_back('{FUNC_MAP, 64'd65536, 8'h00});
    request_queue.push_back('{FUNC_BYTE, 64'hffff_ffff_ffff_ffff, 8'hff});
    request_queue.push_back('{FUNC_BYTE, 64'h0, 8'h00});
    queue_random(12);
    drain();

    // stream cut short mid-value, then nothing fits
    send_idle_pct = 70;
    recv_idle_pct = 11;
    write_capacity(model_pos + 32'd20);
    queue_random(12);
    drain();
    write_capacity(32'h0);
    queue_random(4);
    drain();

    // full capacity, no idling, long output stall
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_capacity(32'hffff_ffff);
    @(posedge clk);
    rx_hold_left = 300;
    queue_random(12);
    drain();
    repeat (10) @(negedge clk);

    $display("%0d requests taken, %0d stream bytes compared, %0d mismatches",
             requests_taken, bytes_seen, errors);
    $display("capacity runs: all ones, cut mid-value, zero, all ones under a long stall");
    if (errors == 0 && expected_stream.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

>>> messagepack_value_encoder_unit.f
sv/mpe_pkg.sv
sv/mpe_if.sv
sv/mpe_front.sv
sv/mpe_queue.sv
sv/mpe_back.sv
sv/messagepack_value_encoder_unit.sv
bench/tb.sv
